[design/midi_byte_message_framer_macros.svh]
// ----------------------------------------------------------------------------
// midi byte message framer assertion macros
// shared helpers for the concurrent checks on the framer ports
// ----------------------------------------------------------------------------
`ifndef MIDI_BYTE_MESSAGE_FRAMER_MACROS_SVH
`define MIDI_BYTE_MESSAGE_FRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MBMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mbmf_pkg.sv]
// ----------------------------------------------------------------------------
// mbmf_pkg
// types and constants shared by the midi byte message framer
// ----------------------------------------------------------------------------
`default_nettype none

package mbmf_pkg;

  // field widths
  localparam int unsigned PortW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaskW = 16;
  localparam int unsigned LenW  = 17;

  // defaults and limits
  localparam int unsigned NumPortsDef = 16;
  localparam int unsigned MaxMsgBytes = 65536;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [LenW-1:0] LenSat   = '1;
  localparam logic [LenW-1:0] MsgLimit = LenW'(MaxMsgBytes);

  // per-word outcome
  typedef enum logic [1:0] {
    ACT_APPEND,
    ACT_COMPLETE,
    ACT_ABORT,
    ACT_REJECT
  } action_e;

  // byte class worked out by the front end
  typedef enum logic [2:0] {
    CLS_DATA,
    CLS_OPEN3,
    CLS_OPEN2,
    CLS_TUNE,
    CLS_RT,
    CLS_SOX,
    CLS_EOX
  } byte_class_e;

  // word between front and back end
  typedef struct packed {
    logic [PortW-1:0] port;
    logic [ByteW-1:0] midi_byte;
    byte_class_e      cls;
  } item_t;

  // word between back end and result queue
  typedef struct packed {
    logic [PortW-1:0] port;
    logic [ByteW-1:0] midi_byte;
    action_e          action;
  } result_t;

endpackage

`default_nettype wire

[design/mbmf_fifo.sv]
// ----------------------------------------------------------------------------
// mbmf_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module mbmf_fifo import mbmf_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/mbmf_front.sv]
// ----------------------------------------------------------------------------
// mbmf_front
// port enable register, port filter and byte classification
// ----------------------------------------------------------------------------
`default_nettype none

module mbmf_front import mbmf_pkg::*; #(
  parameter int unsigned NUM_PORTS = NumPortsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MaskW-1:0] cfg_wdata_i,
  input  wire logic             push_i,
  input  wire logic [PortW-1:0] port_i,
  input  wire logic [ByteW-1:0] midi_byte_i,
  input  wire logic             mid_full_i,
  output logic                  mid_push_o,
  output item_t                 mid_item_o
);

  localparam logic [ByteW-1:0] SysSox      = 8'hF0;
  localparam logic [ByteW-1:0] SysTimeCode = 8'hF1;
  localparam logic [ByteW-1:0] SysSongPos  = 8'hF2;
  localparam logic [ByteW-1:0] SysSongSel  = 8'hF3;
  localparam logic [ByteW-1:0] SysUndefA   = 8'hF4;
  localparam logic [ByteW-1:0] SysUndefB   = 8'hF5;
  localparam logic [ByteW-1:0] SysTuneReq  = 8'hF6;
  localparam logic [ByteW-1:0] SysEox      = 8'hF7;
  localparam logic [3:0]       NibSystem   = 4'hF;
  localparam logic [3:0]       NibProgram  = 4'hC;
  localparam logic [3:0]       NibPressure = 4'hD;

  logic [MaskW-1:0] mask_q;
  logic             port_ok;
  byte_class_e      cls;

  // port enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // byte classification
  always_comb begin
    cls = CLS_RT;
    priority if (!midi_byte_i[ByteW-1]) begin
      cls = CLS_DATA;
    end else if (midi_byte_i[ByteW-1 -: 4] != NibSystem) begin
      cls = ((midi_byte_i[ByteW-1 -: 4] == NibProgram) ||
             (midi_byte_i[ByteW-1 -: 4] == NibPressure)) ? CLS_OPEN2 : CLS_OPEN3;
    end else if ((midi_byte_i == SysTimeCode) || (midi_byte_i == SysSongSel)) begin
      cls = CLS_OPEN2;
    end else if (midi_byte_i == SysSongPos) begin
      cls = CLS_OPEN3;
    end else if (midi_byte_i == SysTuneReq) begin
      cls = CLS_TUNE;
    end else if (midi_byte_i == SysEox) begin
      cls = CLS_EOX;
    end else if ((midi_byte_i == SysSox) || (midi_byte_i == SysUndefA) ||
                 (midi_byte_i == SysUndefB)) begin
      cls = CLS_SOX;
    end else begin
      cls = CLS_RT;
    end
  end

  // drop words for unmapped or disabled ports
  assign port_ok    = (32'(port_i) < NUM_PORTS) && mask_q[port_i];
  assign mid_push_o = push_i && !mid_full_i && port_ok;
  assign mid_item_o = '{port: port_i, midi_byte: midi_byte_i, cls: cls};

endmodule

`default_nettype wire

[design/mbmf_back.sv]
// ----------------------------------------------------------------------------
// mbmf_back
// per-port framing state, read and written back by the back end in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mbmf_back import mbmf_pkg::*; #(
  parameter int unsigned NUM_PORTS = NumPortsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  mid_empty_i,
  input  wire item_t mid_item_i,
  output logic       mid_pop_o,
  input  wire logic  out_full_i,
  output logic       out_push_o,
  output result_t    out_item_o
);

  localparam int unsigned PortCap = 1 << PortW;
  localparam int unsigned Depth   = (NUM_PORTS < PortCap) ? NUM_PORTS : PortCap;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FIXED,
    MODE_SYSEX
  } mode_e;

  mode_e           mode_q [Depth];
  logic [LenW-1:0] exp_q  [Depth];
  logic [LenW-1:0] col_q  [Depth];

  logic [IdxW-1:0] idx;
  logic            go;
  mode_e           mode_r, mode_d;
  logic [LenW-1:0] exp_r, exp_g, exp_d;
  logic [LenW-1:0] col_r, col_inc, col_d;
  logic            room, room_g;
  logic            wr;
  action_e         act;

  assign go         = !mid_empty_i && !out_full_i;
  assign mid_pop_o  = go;
  assign out_push_o = go;
  assign idx        = mid_item_i.port[IdxW-1:0];

  // current state of the addressed port
  assign mode_r  = mode_q[idx];
  assign exp_r   = exp_q[idx];
  assign col_r   = col_q[idx];
  assign exp_g   = (exp_r != LenSat) ? exp_r + 1'b1 : exp_r;
  assign col_inc = col_r + 1'b1;
  assign room    = (col_r < exp_r) && (col_r < MsgLimit);
  assign room_g  = (col_r < exp_g) && (col_r < MsgLimit);

  // framing decision, default is abort and back to idle
  always_comb begin
    act    = ACT_ABORT;
    wr     = 1'b1;
    mode_d = MODE_IDLE;
    exp_d  = '0;
    col_d  = '0;
    unique case (mode_r)
      MODE_FIXED: begin
        unique case (mid_item_i.cls)
          CLS_RT: begin
            if (room_g) begin
              act    = ACT_APPEND;
              mode_d = MODE_FIXED;
              exp_d  = exp_g;
              col_d  = col_inc;
            end
          end
          CLS_DATA: begin
            if (room) begin
              if (col_inc == exp_r) begin
                act = ACT_COMPLETE;
              end else begin
                act    = ACT_APPEND;
                mode_d = MODE_FIXED;
                exp_d  = exp_r;
                col_d  = col_inc;
              end
            end
          end
          default: begin
            act = ACT_ABORT;
          end
        endcase
      end
      MODE_SYSEX: begin
        unique case (mid_item_i.cls)
          CLS_EOX: begin
            act = room_g ? ACT_COMPLETE : ACT_ABORT;
          end
          CLS_DATA, CLS_RT: begin
            if (room_g) begin
              act    = ACT_APPEND;
              mode_d = MODE_SYSEX;
              exp_d  = exp_g;
              col_d  = col_inc;
            end
          end
          default: begin
            act = ACT_ABORT;
          end
        endcase
      end
      default: begin
        // idle port: data bytes are rejected, tune request and realtime complete, other status bytes open a message
        unique case (mid_item_i.cls)
          CLS_DATA: begin
            act = ACT_REJECT;
            wr  = 1'b0;
          end
          CLS_OPEN3: begin
            act    = ACT_APPEND;
            mode_d = MODE_FIXED;
            exp_d  = LenW'(3);
            col_d  = LenW'(1);
          end
          CLS_OPEN2: begin
            act    = ACT_APPEND;
            mode_d = MODE_FIXED;
            exp_d  = LenW'(2);
            col_d  = LenW'(1);
          end
          CLS_TUNE, CLS_RT: begin
            act = ACT_COMPLETE;
          end
          default: begin
            // sysex start, also opened by eox and the undefined codes
            act    = ACT_APPEND;
            mode_d = MODE_SYSEX;
            exp_d  = LenW'(1);
            col_d  = LenW'(1);
          end
        endcase
      end
    endcase
  end

  // per-port state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(Depth); i++) begin
        mode_q[i] <= MODE_IDLE;
        exp_q[i]  <= '0;
        col_q[i]  <= '0;
      end
    end else if (go && wr) begin
      mode_q[idx] <= mode_d;
      exp_q[idx]  <= exp_d;
      col_q[idx]  <= col_d;
    end
  end

  assign out_item_o = '{port: mid_item_i.port, midi_byte: mid_item_i.midi_byte, action: act};

endmodule

`default_nettype wire

[design/midi_byte_message_framer.sv]
// A pushed word is held in the queue between front and back end, then framed
// by the back end and held in the result queue until it is popped.
// Throughput: one byte per cycle while the result queue is not full, set by the
// read-modify-write of the per-port framing state in the back end.
// Reset: all ports idle with zero lengths, port enable mask cleared, queues empty.
// ----------------------------------------------------------------------------
// midi_byte_message_framer
// frames raw midi bytes per output port into complete messages
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_message_framer import mbmf_pkg::*; #(
  parameter int unsigned NUM_PORTS = NumPortsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MaskW-1:0] cfg_wdata_i,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [PortW-1:0] port_i,
  input  wire logic [ByteW-1:0] midi_byte_i,
  input  wire logic             pop,
  output logic                  empty,
  output logic [PortW-1:0]      out_port_o,
  output logic [ByteW-1:0]      out_byte_o,
  output logic [1:0]            action_o
);

  localparam int unsigned ItemW   = $bits(item_t);
  localparam int unsigned ResultW = $bits(result_t);

  logic    mid_push, mid_full, mid_pop, mid_empty;
  item_t   mid_in, mid_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  // front end: filter and classify
  mbmf_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .port_i      (port_i),
    .midi_byte_i (midi_byte_i),
    .mid_full_i  (mid_full),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in)
  );

  assign full = mid_full;

  // queue between front and back end
  mbmf_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // back end: framing state
  mbmf_back #(
    .NUM_PORTS (NUM_PORTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_item_o  (res_in)
  );

  // result queue
  mbmf_fifo #(
    .Width (ResultW),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_port_o = res_out.port;
  assign out_byte_o = res_out.midi_byte;
  assign action_o   = res_out.action;

endmodule

`default_nettype wire

[design/mbmf_checker.sv]
// ----------------------------------------------------------------------------
// mbmf_checker
// port-level checks on the framer result side, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_byte_message_framer_macros.svh"

module mbmf_checker import mbmf_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             pop,
  input wire logic             empty,
  input wire logic [PortW-1:0] out_port_o,
  input wire logic [ByteW-1:0] out_byte_o,
  input wire logic [1:0]       action_o
);

  // a waiting result word holds until popped
  `MBMF_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_port_o) && $stable(out_byte_o) && $stable(action_o), "result word changed while waiting")

  // only data bytes are rejected
  `MBMF_ASSERT_IMPL(a_reject_data, clk_i, rst_ni, !empty && action_o == ACT_REJECT, !out_byte_o[ByteW-1], "status byte marked rejected")

  // a status byte only completes as tune request, eox or realtime
  `MBMF_ASSERT_IMPL(a_complete_status, clk_i, rst_ni, !empty && action_o == ACT_COMPLETE && out_byte_o[ByteW-1], out_byte_o >= 8'hF6, "wrong status byte completed a message")

  // realtime bytes are never rejected
  `MBMF_ASSERT_IMPL(a_rt_accepted, clk_i, rst_ni, !empty && out_byte_o >= 8'hF8, action_o != ACT_REJECT, "realtime byte rejected")

endmodule

bind midi_byte_message_framer mbmf_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .out_port_o (out_port_o),
  .out_byte_o (out_byte_o),
  .action_o   (action_o)
);

`default_nettype wire
